// ----- design/gsm7u_pkg.sv -----
// ----------------------------------------------------------------------------
// gsm7u_pkg
// Shared types, alphabet tables and codes for the GSM 7-bit to UTF-8 decoder.
// ----------------------------------------------------------------------------
package gsm7u_pkg;

	// Configuration register indexes.
	localparam logic CFG_FILL_BITS    = 1'b0;
	localparam logic CFG_SEPTET_COUNT = 1'b1;

	// Septet that switches the next septet to the extension table.
	localparam logic [6:0] ESC_CODE = 7'h1b;

	// One input word.
	typedef struct packed {
		logic [7:0] packed_octet;
		logic       final_octet;
	} gsm7u_in_t;

	// One output word.
	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       run_end;
	} gsm7u_out_t;

	// Up to two septets cut from one octet, in stream order (slot 0 first).
	typedef struct packed {
		logic [1:0]      emit;
		logic [1:0]      ext;
		logic [1:0][6:0] code;
	} gsm7u_septets_t;

	// Up to five UTF-8 bytes for one octet; data[0] goes out first.
	typedef struct packed {
		logic [2:0]      count;
		logic [4:0][7:0] data;
	} gsm7u_bytes_t;

	// Default alphabet: upper byte is the first UTF-8 byte, lower byte the
	// second one or zero for a one-byte character.
	localparam logic [15:0] MAIN_MAP [128] = '{
		16'h4000, 16'hc2a3, 16'h2400, 16'hc2a5, 16'hc3a8, 16'hc3a9, 16'hc3b9, 16'hc3ac,
		16'hc3b2, 16'hc387, 16'h0a00, 16'hc398, 16'hc3b8, 16'h0d00, 16'hc385, 16'hc3a5,
		16'hce94, 16'h5f00, 16'hcea6, 16'hce93, 16'hce9b, 16'hcea9, 16'hcea0, 16'hcea8,
		16'hcea3, 16'hce98, 16'hce9e, 16'h2000, 16'hc386, 16'hc3a6, 16'hc39f, 16'hc389,
		16'h2000, 16'h2100, 16'h2200, 16'h2300, 16'hc2a4, 16'h2500, 16'h2600, 16'h2700,
		16'h2800, 16'h2900, 16'h2a00, 16'h2b00, 16'h2c00, 16'h2d00, 16'h2e00, 16'h2f00,
		16'h3000, 16'h3100, 16'h3200, 16'h3300, 16'h3400, 16'h3500, 16'h3600, 16'h3700,
		16'h3800, 16'h3900, 16'h3a00, 16'h3b00, 16'h3c00, 16'h3d00, 16'h3e00, 16'h3f00,
		16'hc2a1, 16'h4100, 16'h4200, 16'h4300, 16'h4400, 16'h4500, 16'h4600, 16'h4700,
		16'h4800, 16'h4900, 16'h4a00, 16'h4b00, 16'h4c00, 16'h4d00, 16'h4e00, 16'h4f00,
		16'h5000, 16'h5100, 16'h5200, 16'h5300, 16'h5400, 16'h5500, 16'h5600, 16'h5700,
		16'h5800, 16'h5900, 16'h5a00, 16'hc384, 16'hc396, 16'hc391, 16'hc39c, 16'hc2a7,
		16'hc2bf, 16'h6100, 16'h6200, 16'h6300, 16'h6400, 16'h6500, 16'h6600, 16'h6700,
		16'h6800, 16'h6900, 16'h6a00, 16'h6b00, 16'h6c00, 16'h6d00, 16'h6e00, 16'h6f00,
		16'h7000, 16'h7100, 16'h7200, 16'h7300, 16'h7400, 16'h7500, 16'h7600, 16'h7700,
		16'h7800, 16'h7900, 16'h7a00, 16'hc3a4, 16'hc3b6, 16'hc3b1, 16'hc3bc, 16'hc3a0
	};

	// Extension table: [25:24] byte count (zero when the code is not in the
	// table), [7:0] first byte, [15:8] second, [23:16] third.
	function automatic logic [25:0] ext_lookup(input logic [6:0] code);
		logic [25:0] r;
		unique case (code)
			7'h0a:   r = {2'd1, 24'h00000c};
			7'h14:   r = {2'd1, 24'h00005e};
			7'h28:   r = {2'd1, 24'h00007b};
			7'h29:   r = {2'd1, 24'h00007d};
			7'h2f:   r = {2'd1, 24'h00005c};
			7'h3c:   r = {2'd1, 24'h00005b};
			7'h3d:   r = {2'd1, 24'h00007e};
			7'h3e:   r = {2'd1, 24'h00005d};
			7'h40:   r = {2'd1, 24'h00007c};
			7'h65:   r = {2'd3, 24'hac82e2};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/gsm7u_septet_cut.sv -----
// ----------------------------------------------------------------------------
// gsm7u_septet_cut
// Configuration registers, bit stream state and the septet register stage.
// ----------------------------------------------------------------------------
module gsm7u_septet_cut #(
	parameter int unsigned MAX_SEPTETS = 255
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [7:0]                cfg_data,
	input  logic                      octet_valid,
	output logic                      octet_stall,
	input  gsm7u_pkg::gsm7u_in_t      octet,
	output logic                      sep_valid,
	output gsm7u_pkg::gsm7u_septets_t sep,
	input  logic                      sep_take
);
	import gsm7u_pkg::*;

	localparam logic [7:0] CapVal = (MAX_SEPTETS > 255) ? 8'd255 : 8'(MAX_SEPTETS);

	logic [2:0]     fill_bits_q;
	logic [7:0]     septet_count_q;
	logic [13:0]    buf_q;
	logic [3:0]     held_q;
	logic [7:0]     done_q;
	logic           esc_q;
	logic           offset_q;
	logic           sep_valid_s1;
	gsm7u_septets_t sep_s1;

	logic [7:0]     limit;
	logic           active;
	logic [2:0]     skip;
	logic [7:0]     shifted;
	logic [13:0]    buf_w;
	logic [3:0]     held_w;
	logic           took0;
	logic           took1;
	logic [13:0]    buf1;
	logic [3:0]     held1;
	logic [7:0]     done1;
	logic           esc1;
	logic           esc2;
	logic           accept;
	gsm7u_septets_t sep_n;

	assign accept      = octet_valid && !octet_stall;
	assign octet_stall = sep_valid_s1 && !sep_take;

	always_comb begin
		limit   = (septet_count_q < CapVal) ? septet_count_q : CapVal;
		active  = done_q < limit;
		skip    = offset_q ? 3'd0 : fill_bits_q;
		shifted = octet.packed_octet >> skip;
		buf_w   = buf_q | (14'(shifted) << held_q);
		held_w  = held_q + (4'd8 - {1'b0, skip});

		took0 = active && (held_w >= 4'd7);
		buf1  = took0 ? (buf_w >> 7) : buf_w;
		held1 = took0 ? (held_w - 4'd7) : held_w;
		done1 = done_q + 8'(took0);
		// A second full septet, or the zero-padded remainder of the last octet.
		took1 = (done1 < limit) &&
			((held1 >= 4'd7) || (octet.final_octet && (held1 != 4'd0)));

		sep_n.code[0] = buf_w[6:0];
		sep_n.code[1] = buf1[6:0];

		// An escape is swallowed and flags its follower for the extension table.
		sep_n.ext[0]  = esc_q;
		sep_n.emit[0] = took0 && (esc_q || (buf_w[6:0] != ESC_CODE));
		esc1          = took0 ? (!esc_q && (buf_w[6:0] == ESC_CODE)) : esc_q;
		sep_n.ext[1]  = esc1;
		sep_n.emit[1] = took1 && (esc1 || (buf1[6:0] != ESC_CODE));
		esc2          = took1 ? (!esc1 && (buf1[6:0] == ESC_CODE)) : esc1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_bits_q    <= '0;
			septet_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILL_BITS:    fill_bits_q    <= cfg_data[2:0];
				CFG_SEPTET_COUNT: septet_count_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			held_q   <= '0;
			done_q   <= '0;
			esc_q    <= 1'b0;
			offset_q <= 1'b0;
		end else if (accept) begin
			if (octet.final_octet) begin
				buf_q    <= '0;
				held_q   <= '0;
				done_q   <= '0;
				esc_q    <= 1'b0;
				offset_q <= 1'b0;
			end else if (active) begin
				buf_q    <= took1 ? (buf1 >> 7) : buf1;
				held_q   <= took1 ? (held1 - 4'd7) : held1;
				done_q   <= done1 + 8'(took1);
				esc_q    <= esc2;
				offset_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_valid_s1 <= 1'b0;
		end else if (accept) begin
			sep_valid_s1 <= |sep_n.emit;
		end else if (sep_take) begin
			sep_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sep_s1 <= sep_n;
		end
	end

	assign sep_valid = sep_valid_s1;
	assign sep       = sep_s1;

endmodule

// ----- design/gsm7u_char_map.sv -----
// ----------------------------------------------------------------------------
// gsm7u_char_map
// Maps up to two septets to their UTF-8 bytes through the alphabet tables.
// ----------------------------------------------------------------------------
module gsm7u_char_map (
	input  gsm7u_pkg::gsm7u_septets_t sep,
	output gsm7u_pkg::gsm7u_bytes_t   bytes
);
	import gsm7u_pkg::*;

	logic [1:0][1:0]  cnt;
	logic [1:0][23:0] seq;
	logic [25:0]      ext_r [2];
	logic [15:0]      main_r [2];
	logic [2:0]       total;
	logic [39:0]      packed_w;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			ext_r[i]  = ext_lookup(sep.code[i]);
			main_r[i] = MAIN_MAP[sep.code[i]];
			if (!sep.emit[i]) begin
				cnt[i] = 2'd0;
				seq[i] = '0;
			end else if (sep.ext[i] && (ext_r[i][25:24] != 2'd0)) begin
				cnt[i] = ext_r[i][25:24];
				seq[i] = ext_r[i][23:0];
			end else begin
				// Unknown extension codes fall back to the main table.
				cnt[i] = (main_r[i][7:0] != 8'h00) ? 2'd2 : 2'd1;
				seq[i] = {8'h00, main_r[i][7:0], main_r[i][15:8]};
			end
		end
		total    = 3'(cnt[0]) + 3'(cnt[1]);
		packed_w = 40'(seq[0]) | (40'(seq[1]) << {cnt[0], 3'b000});
		bytes.count = (total > 3'd5) ? 3'd5 : total;
		bytes.data  = packed_w;
	end

endmodule

// ----- design/gsm7u_byte_serializer.sv -----
// ----------------------------------------------------------------------------
// gsm7u_byte_serializer
// Output register that sends the bytes of one octet one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module gsm7u_byte_serializer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sep_valid,
	output logic                    sep_take,
	input  gsm7u_pkg::gsm7u_bytes_t bytes,
	output logic                    text_valid,
	input  logic                    text_stall,
	output gsm7u_pkg::gsm7u_out_t   text
);
	import gsm7u_pkg::*;

	logic [2:0]      cnt_q;
	logic [4:0][7:0] data_q;
	logic            take_out;

	assign take_out = text_valid && !text_stall;
	// Refill when empty or when the last byte of the current run leaves.
	assign sep_take = sep_valid && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && take_out));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (sep_take) begin
			cnt_q <= bytes.count;
		end else if (take_out) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (sep_take) begin
			data_q <= bytes.data;
		end else if (take_out) begin
			data_q <= data_q >> 8;
		end
	end

	assign text_valid     = cnt_q != 3'd0;
	assign text.utf8_byte = data_q[0];
	assign text.run_end   = cnt_q == 3'd1;

endmodule

// ----- design/gsm7_unpack_to_utf8_unit.sv -----
// ----------------------------------------------------------------------------
// gsm7_unpack_to_utf8_unit
// Streaming GSM 7-bit default alphabet to UTF-8 decoder, one octet per word.
// ----------------------------------------------------------------------------
// The octet channel (octet_valid, octet_stall, octet) carries packed 7-bit
// data, bit 0 first, with final_octet set on the last word of a message.
// The text channel (text_valid, text_stall, text) returns UTF-8 bytes one
// word at a time; run_end marks the last byte caused by one octet, and an
// octet that causes no byte produces no word at all.
// The configuration port writes fill_bits (index 0) and septet_count
// (index 1); the user must write only while idle, the block does not check.
// An accepted octet is cut into septets in the same cycle and lands in the
// septet register; the serializer loads it from there once it is empty or
// its last byte leaves, and then presents the first byte. A new octet is
// taken every cycle while the septet register can move on; an octet that
// yields n bytes holds the serializer until all n are sent, one byte per
// cycle while the receiver does not stall, so the sustained rate is set by
// the output byte count.
// Reset clears the registers, the stream state and both stages. When the
// receiver stalls, the current byte holds, one further octet waits in the
// septet register, and then octet_stall rises.
// ----------------------------------------------------------------------------
module gsm7_unpack_to_utf8_unit #(
	parameter int unsigned MAX_SEPTETS = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  octet_valid,
	output logic                  octet_stall,
	input  gsm7u_pkg::gsm7u_in_t  octet,
	output logic                  text_valid,
	input  logic                  text_stall,
	output gsm7u_pkg::gsm7u_out_t text
);
	import gsm7u_pkg::*;

	logic           sep_valid;
	logic           sep_take;
	gsm7u_septets_t sep;
	gsm7u_bytes_t   bytes;

	// Stream state and septet register.
	gsm7u_septet_cut #(
		.MAX_SEPTETS(MAX_SEPTETS)
	) u_cut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.octet_valid(octet_valid),
		.octet_stall(octet_stall),
		.octet      (octet),
		.sep_valid  (sep_valid),
		.sep        (sep),
		.sep_take   (sep_take)
	);

	// Table lookup between the two registers.
	gsm7u_char_map u_map (
		.sep  (sep),
		.bytes(bytes)
	);

	// Output register, one byte per word.
	gsm7u_byte_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.sep_valid (sep_valid),
		.sep_take  (sep_take),
		.bytes     (bytes),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text      (text)
	);

	// A run that is not finished continues in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && !text.run_end |=> text_valid)
		else $error("byte run broken before run_end");

	// The septet register only holds work that produces bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		sep_valid |-> (|sep.emit) && (bytes.count != 3'd0))
		else $error("septet register holds an empty item");

	// The octet side stalls only while the septet register is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		octet_stall |-> sep_valid && !sep_take)
		else $error("octet stall without a waiting item");

	// After a load the serializer presents a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		sep_take |=> text_valid)
		else $error("load did not present a byte");

endmodule
